// ===== rtl/mbps_pkg.sv =====
// Shared types and constants for the masked byte pattern scanner.
`default_nettype none

package mbps_pkg;

  localparam int PatternBytes           = 16;
  localparam int MaxPatternBytesDefault = 16;
  localparam int AddrWidth              = 48;
  localparam int SizeWidth              = 32;
  localparam int LenWidth               = 5;
  localparam int MaskWidth              = 16;
  localparam int ApbDataWidth           = 64;
  localparam int ApbAddrWidth           = 6;
  localparam int RegIndexWidth          = 3;

  typedef enum logic [RegIndexWidth-1:0] {
    REG_BASE_ADDRESS   = 3'd0,
    REG_SCAN_SIZE      = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_COMPARE_MASK   = 3'd3,
    REG_PATTERN_LOW    = 3'd4,
    REG_PATTERN_HIGH   = 3'd5
  } reg_index_t;

  // Settings every window cell needs for its own compare.
  typedef struct packed {
    logic [LenWidth-1:0]               pattern_length;
    logic [MaskWidth-1:0]              compare_mask;
    logic [PatternBytes-1:0][7:0]      pattern;
  } match_cfg_t;

  // Full register set as seen by the scan control.
  typedef struct packed {
    logic [AddrWidth-1:0] base_address;
    logic [SizeWidth-1:0] scan_size;
    match_cfg_t           match;
  } scan_regs_t;

endpackage

`default_nettype wire

// ===== rtl/mbps_regs.sv =====
// APB register file holding the scan region and the pattern settings.
`default_nettype none

module mbps_regs
  import mbps_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ApbAddrWidth-1:0] paddr,
  input  wire logic [ApbDataWidth-1:0] pwdata,
  output logic      [ApbDataWidth-1:0] prdata,
  output scan_regs_t                   regs
);

  logic       write_en;
  reg_index_t index;

  assign write_en = psel & penable & pwrite;
  assign index    = reg_index_t'(paddr[ApbAddrWidth-1:ApbAddrWidth-RegIndexWidth]);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (write_en) begin
      unique case (index)
        REG_BASE_ADDRESS:   regs.base_address         <= pwdata[AddrWidth-1:0];
        REG_SCAN_SIZE:      regs.scan_size            <= pwdata[SizeWidth-1:0];
        REG_PATTERN_LENGTH: regs.match.pattern_length <= pwdata[LenWidth-1:0];
        REG_COMPARE_MASK:   regs.match.compare_mask   <= pwdata[MaskWidth-1:0];
        REG_PATTERN_LOW:    regs.match.pattern[7:0]   <= pwdata;
        REG_PATTERN_HIGH:   regs.match.pattern[15:8]  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_BASE_ADDRESS:   prdata = {{(ApbDataWidth-AddrWidth){1'b0}}, regs.base_address};
      REG_SCAN_SIZE:      prdata = {{(ApbDataWidth-SizeWidth){1'b0}}, regs.scan_size};
      REG_PATTERN_LENGTH: prdata = {{(ApbDataWidth-LenWidth){1'b0}},
                                    regs.match.pattern_length};
      REG_COMPARE_MASK:   prdata = {{(ApbDataWidth-MaskWidth){1'b0}},
                                    regs.match.compare_mask};
      REG_PATTERN_LOW:    prdata = regs.match.pattern[7:0];
      REG_PATTERN_HIGH:   prdata = regs.match.pattern[15:8];
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mbps_cell.sv =====
// One window cell: holds one byte, passes it on and checks it against its pattern byte.
`default_nettype none

module mbps_cell
  import mbps_pkg::*;
#(
  parameter int CellIndex = 0
) (
  input  wire logic       clk,
  input  wire logic       shift,
  input  wire logic [7:0] shift_in,
  input  wire match_cfg_t cfg,
  output logic      [7:0] held_byte,
  output logic            hit
);

  int idx;

  // The cell is checked against the value it will hold after this shift.
  always_comb begin
    idx = int'(cfg.pattern_length) - 1 - CellIndex;
    hit = 1'b1;
    if (CellIndex < int'(cfg.pattern_length) && idx < PatternBytes) begin
      if (cfg.compare_mask[idx[3:0]]) begin
        hit = (shift_in == cfg.pattern[idx[3:0]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      held_byte <= shift_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/masked_byte_pattern_scanner.sv =====
// Top level of the masked byte pattern scanner: scan control, window chain and result register.
`default_nettype none

// The scanner takes the bytes of a memory region one item per cycle on the byte
// channel (data_byte, first_of_scan, byte_valid/byte_ready). An item with
// first_of_scan set marks the byte at base_address and always starts a new scan;
// other items are ignored while no scan is running. The bytes shift through a
// row of window cells, each comparing its byte with the pattern byte that its
// position stands for under the current pattern_length, so a whole window is
// checked in the cycle the byte arrives.
// Each scan that runs to its end yields exactly one item on the result channel (found,
// match_address, result_valid/result_ready): found set with the start address of the
// first match, or found clear with address zero once scan_size bytes have gone by
// unmatched. The result is registered and appears in the cycle after the byte that caused it
// was accepted. Throughput is one byte per cycle; the result register lets a new byte in at
// the same edge at which the waiting result is taken, and byte_ready drops only while a result
// is held and result_ready is low. The user must write registers over the APB port only while
// no scan is running; the block does not enforce it. Reset clears the registers, leaves the
// block idle and drops result_valid; no clearing pass is needed.
module masked_byte_pattern_scanner
  import mbps_pkg::*;
#(
  parameter int MaxPatternBytes = MaxPatternBytesDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ApbAddrWidth-1:0] paddr,
  input  wire logic [ApbDataWidth-1:0] pwdata,
  output logic      [ApbDataWidth-1:0] prdata,
  output logic                         pready,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    first_of_scan,
  input  wire logic                    byte_valid,
  output logic                         byte_ready,
  output logic                         found,
  output logic      [AddrWidth-1:0]    match_address,
  output logic                         result_valid,
  input  wire logic                    result_ready
);

  scan_regs_t regs;

  // Scan state.
  logic                 scan_finished;
  logic [SizeWidth-1:0] bytes_seen;

  // Window chain.
  logic [7:0]                 cell_byte [MaxPatternBytes];
  logic [MaxPatternBytes-1:0] cell_hit;

  // Per-item decisions.
  logic                 accept;
  logic                 empty_region;
  logic                 active;
  logic                 shift;
  logic [SizeWidth-1:0] seen_inc;
  logic                 length_ok;
  logic                 window_hit;
  logic                 region_end;
  logic                 emit;
  logic                 emit_found;
  logic [AddrWidth-1:0] hit_address;
  logic                 scan_finished_next;

  assign pready = 1'b1;

  mbps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .regs    (regs)
  );

  // The newest byte enters cell 0 and moves one cell further on every shift.
  for (genvar k = 0; k < MaxPatternBytes; k++) begin : g_cell
    logic [7:0] feed;
    if (k == 0) begin : g_head
      assign feed = data_byte;
    end else begin : g_body
      assign feed = cell_byte[k-1];
    end
    mbps_cell #(
      .CellIndex (k)
    ) u_cell (
      .clk       (clk),
      .shift     (shift),
      .shift_in  (feed),
      .cfg       (regs.match),
      .held_byte (cell_byte[k]),
      .hit       (cell_hit[k])
    );
  end

  // A new byte may come in whenever the result register is free or being emptied.
  assign byte_ready = !result_valid || result_ready;
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    empty_region = first_of_scan && (regs.scan_size == '0);
    active       = first_of_scan ? !empty_region : !scan_finished;
    seen_inc     = (first_of_scan ? '0 : bytes_seen) + SizeWidth'(1);
    length_ok    = (regs.match.pattern_length >= LenWidth'(2)) &&
                   (int'(regs.match.pattern_length) <= MaxPatternBytes);
    // A match needs the whole pattern to lie inside the bytes of this scan.
    window_hit   = length_ok &&
                   (seen_inc >= {{(SizeWidth-LenWidth){1'b0}}, regs.match.pattern_length}) &&
                   (&cell_hit);
    region_end   = seen_inc >= regs.scan_size;
    shift        = accept && active;
    emit         = accept && (empty_region || (active && (window_hit || region_end)));
    emit_found   = active && window_hit;
    hit_address  = regs.base_address + {{(AddrWidth-SizeWidth){1'b0}}, seen_inc}
                   - {{(AddrWidth-LenWidth){1'b0}}, regs.match.pattern_length};

    scan_finished_next = scan_finished;
    if (accept) begin
      if (first_of_scan) begin
        scan_finished_next = empty_region;
      end
      if (active && (window_hit || region_end)) begin
        scan_finished_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_finished <= 1'b1;
      bytes_seen    <= '0;
    end else begin
      scan_finished <= scan_finished_next;
      if (shift) begin
        bytes_seen <= seen_inc;
      end else if (accept && first_of_scan) begin
        bytes_seen <= '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found         <= emit_found;
      match_address <= emit_found ? hit_address : '0;
    end
  end

  // An unmatched region always reports address zero.
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> match_address == '0)
    else $error("not-found result carries a non-zero address");

  // Every result closes its scan.
  a_result_closes_scan: assert property (@(posedge clk) disable iff (rst)
    emit |=> scan_finished)
    else $error("scan still running after a result");

  // Bytes arriving outside a scan leave the byte count alone.
  a_idle_count_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !first_of_scan && scan_finished |=> $stable(bytes_seen))
    else $error("byte count moved while no scan was running");

  // With the result register empty the byte channel is never held off.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> byte_ready)
    else $error("byte channel stalled with an empty result register");

endmodule

`default_nettype wire
